/* hdl/sclcg_pkg.sv */
// Shared constants and types for the shuffled combined LCG generator.
`default_nettype none

package sclcg_pkg;

    // Word widths of the generator state and of the scaled fraction.
    localparam int WORD_W = 31;
    localparam int FRAC_W = 24;

    // First and second generator: multiplier, modulus and 2^31 - modulus.
    localparam logic [WORD_W-1:0] MOD_A    = 31'd2147483563;
    localparam logic [WORD_W-1:0] MOD_B    = 31'd2147483399;
    localparam logic [15:0]       MUL_A    = 16'd40014;
    localparam logic [15:0]       MUL_B    = 16'd40692;
    localparam logic [7:0]        FOLD_D_A = 8'd85;
    localparam logic [7:0]        FOLD_D_B = 8'd249;

    // Output folding bound, fraction clamp and reset values.
    localparam logic [WORD_W-1:0] FOLD_TOP     = 31'd2147483562;
    localparam logic [FRAC_W-1:0] FRAC_MAX     = 24'd16777214;
    localparam logic [WORD_W-1:0] SEED_B_RESET = 31'd123456789;
    localparam logic [WORD_W-1:0] SEED_ONE     = 31'd1;

    // Table depth default and number of discarded warm-up steps.
    localparam int TBL_DEPTH_DEF = 32;
    localparam int WARMUP_EXTRA  = 8;

    // Command codes.
    typedef enum logic [1:0] {
        OP_DRAW   = 2'd0,
        OP_RESEED = 2'd1,
        OP_LOAD   = 2'd2
    } op_t;

    // Which generator the shared modular multiplier works for.
    typedef enum logic {
        GEN_A = 1'b0,
        GEN_B = 1'b1
    } gen_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WARM_MUL,
        ST_WARM_RED,
        ST_SLOT_EST,
        ST_SLOT_FIX,
        ST_DRAW_A,
        ST_DRAW_B,
        ST_DRAW_MIX,
        ST_FIN_EST,
        ST_FIN_OUT
    } state_t;

endpackage

`default_nettype wire

/* hdl/shuffled_combined_lcg_generator.sv */
// Top level of the shuffled combined LCG generator with its command sequencer.
//
// A command is taken when start is high and busy is low; each command gives
// exactly one word on raw_value and unit_fraction, marked by done for a single
// cycle, and the receiver cannot hold it off. A plain draw or a state load runs
// through DRAW_A, DRAW_B, DRAW_MIX, FIN_EST and FIN_OUT, with done in FIN_OUT:
// two passes through the shared modular multiplier, a table read-modify-write
// and two scaling steps. A reseed (or a draw that finds the first generator at
// zero, or a load of zero) first runs TABLE_DEPTH+8 warm-up steps (the default
// depth is 32), each a pass of the modular multiplier loop through WARM_MUL and
// WARM_RED, followed by SLOT_EST and SLOT_FIX.
`default_nettype none

module shuffled_combined_lcg_generator
    import sclcg_pkg::*;
#(
    parameter int TABLE_DEPTH = TBL_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        operation,
    input  wire logic [WORD_W-1:0] seed_value,
    output logic                   done,
    output logic      [WORD_W-1:0] raw_value,
    output logic      [FRAC_W-1:0] unit_fraction
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + WARMUP_EXTRA);

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] x1_reg, x1_next;
    logic [WORD_W-1:0] x2_reg, x2_next;
    logic [WORD_W-1:0] last_reg, last_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;

    logic [WORD_W-1:0] mm_x;
    gen_t              mm_sel;
    logic [WORD_W-1:0] mm_res;

    logic              tbl_rd;
    logic              tbl_wr;
    logic [AW-1:0]     tbl_wr_addr;
    logic [WORD_W-1:0] tbl_rdata;

    logic              frac_en;
    logic [AW-1:0]     sc_slot;

    logic [WORD_W-1:0] x1_eff;
    logic [WORD_W-1:0] reseed_val;
    logic              need_reseed;
    logic [WORD_W:0]   diff;
    logic [WORD_W:0]   diff_fold;

    // Shared modular multiplier for both generators.
    sclcg_mulmod u_mulmod (
        .clk (clk),
        .x   (mm_x),
        .sel (mm_sel),
        .res (mm_res)
    );

    // Shuffle table.
    sclcg_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (tbl_rd),
        .rd_addr (slot_reg),
        .wr_en   (tbl_wr),
        .wr_addr (tbl_wr_addr),
        .wr_data (mm_res),
        .rd_data (tbl_rdata)
    );

    // Slot and fraction from the last output word.
    sclcg_scale #(
        .DEPTH (TABLE_DEPTH)
    ) u_scale (
        .clk      (clk),
        .value    (last_reg),
        .frac_en  (frac_en),
        .slot     (sc_slot),
        .fraction (unit_fraction)
    );

    // Command decode: reseed on request, or when the first state would be zero.
    always_comb
    begin
        x1_eff      = x1_reg;
        need_reseed = 1'b0;
        reseed_val  = SEED_ONE;
        case (op_t'(operation))
            OP_RESEED:
            begin
                need_reseed = 1'b1;
                reseed_val  = (seed_value == '0) ? SEED_ONE : seed_value;
            end
            OP_LOAD:
            begin
                x1_eff      = seed_value;
                need_reseed = (seed_value == '0);
            end
            OP_DRAW:
            begin
                need_reseed = (x1_reg == '0);
            end
            default:
            begin
                need_reseed = (x1_reg == '0);
            end
        endcase
    end

    // Combined output: table entry minus second state, folded into range.
    always_comb
    begin
        diff      = {1'b0, tbl_rdata} - {1'b0, mm_res};
        diff_fold = (diff[WORD_W] || (diff == '0)) ? diff + {1'b0, FOLD_TOP} : diff;
    end

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            x1_reg    <= SEED_ONE;
            x2_reg    <= SEED_B_RESET;
            last_reg  <= '0;
            slot_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            last_reg  <= last_next;
            slot_reg  <= slot_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Sequencer: next state, datapath updates and strobes.
    always_comb
    begin
        state_next  = state_reg;
        x1_next     = x1_reg;
        x2_next     = x2_reg;
        last_next   = last_reg;
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        mm_x        = x1_reg;
        mm_sel      = GEN_A;
        tbl_rd      = 1'b0;
        tbl_wr      = 1'b0;
        tbl_wr_addr = slot_reg;
        frac_en     = 1'b0;
        done        = 1'b0;
        busy        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (need_reseed)
                    begin
                        x1_next    = reseed_val;
                        x2_next    = reseed_val;
                        cnt_next   = CNTW'(TABLE_DEPTH + WARMUP_EXTRA - 1);
                        state_next = ST_WARM_MUL;
                    end
                    else
                    begin
                        x1_next    = x1_eff;
                        state_next = ST_DRAW_A;
                    end
                end
            end
            ST_WARM_MUL:
            begin
                state_next = ST_WARM_RED;
            end
            ST_WARM_RED:
            begin
                // The last warm-up values fill the table from the top down.
                x1_next     = mm_res;
                tbl_wr      = (cnt_reg < CNTW'(TABLE_DEPTH));
                tbl_wr_addr = cnt_reg[AW-1:0];
                if (cnt_reg == '0)
                begin
                    last_next  = mm_res;
                    state_next = ST_SLOT_EST;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNTW'(1);
                    state_next = ST_WARM_MUL;
                end
            end
            ST_SLOT_EST:
            begin
                state_next = ST_SLOT_FIX;
            end
            ST_SLOT_FIX:
            begin
                slot_next  = sc_slot;
                state_next = ST_DRAW_A;
            end
            ST_DRAW_A:
            begin
                tbl_rd     = 1'b1;
                state_next = ST_DRAW_B;
            end
            ST_DRAW_B:
            begin
                // New first state replaces the entry that was just read.
                x1_next    = mm_res;
                tbl_wr     = 1'b1;
                mm_x       = x2_reg;
                mm_sel     = GEN_B;
                state_next = ST_DRAW_MIX;
            end
            ST_DRAW_MIX:
            begin
                x2_next    = mm_res;
                last_next  = diff_fold[WORD_W-1:0];
                state_next = ST_FIN_EST;
            end
            ST_FIN_EST:
            begin
                frac_en    = 1'b1;
                state_next = ST_FIN_OUT;
            end
            ST_FIN_OUT:
            begin
                done       = 1'b1;
                slot_next  = sc_slot;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign raw_value = last_reg;

endmodule

`default_nettype wire

/* hdl/sclcg_mulmod.sv */
// Shared modular multiplier: x * mul mod (2^31 - d), product registered, reduction combinational.
`default_nettype none

module sclcg_mulmod
    import sclcg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [WORD_W-1:0] x,
    input  wire gen_t              sel,
    output logic      [WORD_W-1:0] res
);

    logic [15:0]         mul;
    logic [46:0]         prod_reg;
    gen_t                sel_reg;
    logic [7:0]          fold_d;
    logic [WORD_W-1:0]   modulus;
    logic [23:0]         hi_scaled;
    logic [31:0]         folded;
    logic [31:0]         reduced;

    // Full product of the state and the generator multiplier.
    assign mul = (sel == GEN_B) ? MUL_B : MUL_A;

    always_ff @(posedge clk)
    begin
        prod_reg <= {16'd0, x} * {31'd0, mul};
        sel_reg  <= sel;
    end

    // Since 2^31 is congruent to d, the high part folds in as hi * d.
    // The folded sum stays below twice the modulus, so one subtract finishes it.
    always_comb
    begin
        fold_d    = (sel_reg == GEN_B) ? FOLD_D_B : FOLD_D_A;
        modulus   = (sel_reg == GEN_B) ? MOD_B : MOD_A;
        hi_scaled = {8'd0, prod_reg[46:31]} * {16'd0, fold_d};
        folded    = {8'd0, hi_scaled} + {1'b0, prod_reg[30:0]};
        reduced   = folded - {1'b0, modulus};
        res       = (folded >= {1'b0, modulus}) ? reduced[WORD_W-1:0]
                                                : folded[WORD_W-1:0];
    end

endmodule

`default_nettype wire

/* hdl/sclcg_table.sv */
// Shuffle table memory with per-entry valid bits so that reset reads as zero.
`default_nettype none

module sclcg_table
    import sclcg_pkg::*;
#(
    parameter int DEPTH = TBL_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    output logic      [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic [DEPTH-1:0]  vld_reg;
    logic              rvld_reg;

    // Storage array and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Valid bits: an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvld_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

/* hdl/sclcg_scale.sv */
// Output scaling: table slot for the next draw and the 24-bit fraction.
`default_nettype none

module sclcg_scale
    import sclcg_pkg::*;
#(
    parameter int DEPTH = TBL_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic [WORD_W-1:0] value,
    input  wire logic              frac_en,
    output logic      [AW-1:0]     slot,
    output logic      [FRAC_W-1:0] fraction
);

    // Slot divisor and its truncated reciprocal scaled by 2^31.
    localparam longint SLOT_DIV = 64'd1 + longint'(FOLD_TOP) / longint'(DEPTH);
    localparam longint RECIP    = (64'd1 << WORD_W) / SLOT_DIV;
    localparam int     RW       = $clog2(RECIP + 1);
    localparam int     PW       = WORD_W + RW;
    localparam int     BW       = RW + 1 + WORD_W;

    logic [PW-1:0]     est_prod;
    logic [RW-1:0]     est_reg;
    logic [RW:0]       est_next;
    logic [BW-1:0]     bound;
    logic [RW:0]       slot_full;
    logic [RW:0]       slot_sat;
    logic [24:0]       q_lo;
    logic [24:0]       q_hi;
    logic [31:0]       lhs;
    logic [31:0]       rhs;
    logic [24:0]       q_sel;
    logic [FRAC_W-1:0] frac_reg;

    // First step: estimate the quotient, at most one below the true one.
    assign est_prod = {{RW{1'b0}}, value} * {{WORD_W{1'b0}}, RW'(RECIP)};

    always_ff @(posedge clk)
    begin
        est_reg <= est_prod[PW-1:WORD_W];
    end

    // Second step: correct the estimate by one and saturate at the top entry.
    always_comb
    begin
        est_next  = {1'b0, est_reg} + {{RW{1'b0}}, 1'b1};
        bound     = {{WORD_W{1'b0}}, est_next} * BW'(SLOT_DIV);
        slot_full = ({{(BW-WORD_W){1'b0}}, value} >= bound) ? est_next
                                                             : {1'b0, est_reg};
        slot_sat  = (slot_full > (RW+1)'(DEPTH - 1)) ? (RW+1)'(DEPTH - 1) : slot_full;
        slot      = slot_sat[AW-1:0];
    end

    // Fraction: value / 128 is exact or one short of value * 2^24 / modulus.
    always_comb
    begin
        q_lo  = {1'b0, value[WORD_W-1:7]};
        q_hi  = q_lo + 25'd1;
        lhs   = {7'd0, q_hi} * {24'd0, FOLD_D_A};
        rhs   = {8'd128 - {1'b0, value[6:0]}, 24'd0};
        q_sel = (lhs >= rhs) ? q_hi : q_lo;
    end

    always_ff @(posedge clk)
    begin
        if (frac_en)
        begin
            frac_reg <= (q_sel > {1'b0, FRAC_MAX}) ? FRAC_MAX : q_sel[FRAC_W-1:0];
        end
    end

    assign fraction = frac_reg;

endmodule

`default_nettype wire
